FILE: sv/edfq_pkg.sv
// shared types and constants of the deadline-sorted ready queue
`timescale 1ns / 1ps
package edfq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CAP_W     = 5;
	localparam int OCC_W     = 5;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// register word index of queue_capacity
	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_SERVE  = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_SERVED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  task_id;
		logic [15:0] task_deadline;
		logic [15:0] task_time;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [7:0]       out_id;
		logic [15:0]      out_deadline;
		logic [15:0]      out_time;
		logic             may_miss;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] deadline;
		logic [15:0] time_need;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

FILE: sv/edf_sorted_ready_queue_unit.sv
// top level of the deadline-sorted ready queue: register port, sequencer, result register
`timescale 1ns / 1ps
// Earliest-deadline-first ready queue holding up to DEPTH tasks in a single-port
// slot ram used as a circular buffer. One request is taken at a time: req_ready
// is high only while the sequencer is idle. A serve passes through S_DECIDE and
// S_SRV_RD to S_FIN; a refused or empty request goes from S_DECIDE to S_FIN.
// An insert walks back from the tail through the one ram port, alternating
// S_INS_RD and S_INS_CMP for each stored entry with a later deadline that moves
// up one slot (at most DEPTH-1 such entries); when the walk reaches the front,
// the new entry is written there from S_INS_RD.
// A finished response sits in an output register, so the next request can be
// accepted while it waits to be taken. queue_capacity lives at byte address 0
// and only limits inserts; entries already held are kept if it is lowered.
module edf_sorted_ready_queue_unit #(
	parameter int DEPTH = edfq_pkg::DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        req_valid,
	output logic                        req_ready,
	input  edfq_pkg::req_t              req,
	// response channel
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output edfq_pkg::rsp_t              rsp,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [edfq_pkg::ADDR_W-1:0] paddr,
	input  logic [edfq_pkg::DATA_W-1:0] pwdata,
	output logic [edfq_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	import edfq_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             res_valid;
	logic             res_ready;
	rsp_t             res;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             reg_sel;

	// word index of the addressed register
	assign reg_sel = (paddr[2] == REG_CAPACITY);
	assign pready  = 1'b1;

	// capacity register, written in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = reg_sel ? DATA_W'(cap_q) : '0;

	edfq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cap      (cap_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register, refilled in the cycle it is emptied
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sv/edfq_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module edfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/edfq_ctrl.sv
// sequencer: sorted insert walk and front removal over a circular slot ram
`timescale 1ns / 1ps
module edfq_ctrl #(
	parameter int DEPTH = edfq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  edfq_pkg::req_t             req,
	input  logic [edfq_pkg::CAP_W-1:0] cap,
	output logic                       res_valid,
	input  logic                       res_ready,
	output edfq_pkg::rsp_t             res
);

	import edfq_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DECIDE  = 6'b000010,
		S_INS_RD  = 6'b000100,
		S_INS_CMP = 6'b001000,
		S_SRV_RD  = 6'b010000,
		S_FIN     = 6'b100000
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [PTR_W-1:0] i_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       status_q;
	slot_t            out_slot_q;
	logic             miss_q;

	logic [PTR_W-1:0] lidx;
	logic [PTR_W:0]   sum;
	logic [PTR_W-1:0] phys;
	logic             we;
	slot_t            wdata;
	slot_t            rdata;
	slot_t            new_slot;
	logic             later;
	logic             full;
	logic [CMP_W-1:0] count_ext;
	logic [CMP_W-1:0] cap_ext;
	logic [CNT_W+OCC_W-1:0] occ_ext;

	assign new_slot = '{id: req_q.task_id, deadline: req_q.task_deadline,
		time_need: req_q.task_time};

	// logical to physical slot: one add and one wrap correction
	assign lidx = (state_q == S_INS_RD && i_q != '0) ? i_q - PTR_W'(1) : i_q;
	always_comb begin
		sum  = {1'b0, head_q} + {1'b0, (state_q == S_DECIDE) ? PTR_W'(0) : lidx};
		phys = (sum >= DEPTH_P) ? PTR_W'(sum - DEPTH_P) : sum[PTR_W-1:0];
	end

	// shared deadline compare
	assign later = rdata.deadline > req_q.task_deadline;

	assign count_ext = CMP_W'(count_q);
	assign cap_ext   = CMP_W'(cap);
	assign full      = (count_ext >= cap_ext) || (count_q == DEPTH_C);

	always_comb begin
		we    = 1'b0;
		wdata = new_slot;
		unique case (state_q)
			S_INS_RD: begin
				we = (i_q == '0);
			end
			S_INS_CMP: begin
				we = 1'b1;
				if (later) begin
					wdata = rdata;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	edfq_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(phys),
		.wdata(wdata),
		.raddr(phys),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (req_q.req_type == REQ_INSERT) begin
						state_q <= full ? S_FIN : S_INS_RD;
						i_q     <= count_q[PTR_W-1:0];
					end else begin
						state_q <= (count_q == '0) ? S_FIN : S_SRV_RD;
					end
				end
				S_INS_RD: begin
					if (i_q == '0) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (later) begin
						i_q     <= i_q - PTR_W'(1);
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_SRV_RD: begin
					head_q  <= (head_q == LAST_P) ? '0 : head_q + PTR_W'(1);
					count_q <= count_q - CNT_W'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_DECIDE) begin
			out_slot_q <= '0;
			miss_q     <= 1'b0;
			if (req_q.req_type == REQ_INSERT) begin
				status_q <= full ? ST_FULL : ST_INSERTED;
			end else begin
				status_q <= (count_q == '0) ? ST_EMPTY : ST_SERVED;
			end
		end
		if (state_q == S_SRV_RD) begin
			out_slot_q <= rdata;
			miss_q     <= rdata.time_need > rdata.deadline;
		end
	end

	assign occ_ext   = {{OCC_W{1'b0}}, count_q};
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res = '{status: status_q, out_id: out_slot_q.id,
		out_deadline: out_slot_q.deadline, out_time: out_slot_q.time_need,
		may_miss: miss_q, occupancy: occ_ext[OCC_W-1:0]};

endmodule
